FILE: rtl/fpt64_pkg.sv
// Package for the 64-bit Fermat probable-prime tester.
// Holds the operand widths and the fixed table of Fermat bases; depends on nothing.
`default_nettype none

package fpt64_pkg;

    localparam int CAND_WIDTH = 64;
    localparam int NUM_WIDTH  = 64;
    localparam int NUM_BASES  = 4;
    localparam int BASE_IDX_W = $clog2(NUM_BASES);

    typedef logic [NUM_WIDTH-1:0]  t_num;
    typedef logic [NUM_WIDTH:0]    t_wide;
    typedef logic [BASE_IDX_W-1:0] t_base_idx;

    function automatic t_num fpt64_base(input t_base_idx idx);
        logic [3:0] b;
        case (idx)
            2'd0:    b = 4'd2;
            2'd1:    b = 4'd3;
            2'd2:    b = 4'd7;
            default: b = 4'd11;
        endcase
        return t_num'(b);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fermat_prime_test_64_top.sv
// Per base: the base is loaded and reduced below the candidate by repeated subtraction, then the
// bits of candidate-1 are walked from the lowest, where each bit adds a modular squaring and a
// set bit a multiply too, each by shift-and-add: a doubling per bit of its multiplier and an add
// per set bit. A failing base ends early. The verdict is held in a result register.
// Throughput: one request at a time, set by the shared modular adder; a new request is taken while
// the previous result waits. Reset (synchronous, active low) idles the sequencer, drops o_valid.
`default_nettype none

module fermat_prime_test_64_top
    import fpt64_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [CAND_WIDTH-1:0] i_candidate,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_is_probable_prime
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_REDUCE,
        S_POW,
        S_MUL,
        S_CHECK,
        S_DONE
    } t_state;

    t_state    r_state;
    t_num      r_n;
    t_num      r_e;
    t_num      r_b;
    t_num      r_r;
    t_num      r_x;
    t_num      r_y;
    t_num      r_acc;
    logic      r_dst_r;
    logic      r_add_done;
    t_base_idx r_idx;
    logic      r_pass;
    logic      r_out_valid;
    logic      r_result;

    t_num  w_ua;
    t_num  w_ub;
    t_wide w_sum;
    t_wide w_diff;
    logic  w_ge;
    t_num  w_res;
    logic  w_do_add;

    assign w_do_add = r_y[0] && !r_add_done;

    always_comb begin
        if (r_state == S_REDUCE) begin
            w_ua = r_b;
            w_ub = '0;
        end else if (w_do_add) begin
            w_ua = r_acc;
            w_ub = r_x;
        end else begin
            w_ua = r_x;
            w_ub = r_x;
        end
    end

    assign w_sum  = {1'b0, w_ua} + {1'b0, w_ub};
    assign w_diff = w_sum - {1'b0, r_n};
    assign w_ge   = (w_sum >= {1'b0, r_n});
    assign w_res  = w_ge ? w_diff[NUM_WIDTH-1:0] : w_sum[NUM_WIDTH-1:0];

    assign o_ready             = (r_state == S_IDLE);
    assign o_valid             = r_out_valid;
    assign o_is_probable_prime = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_pass      <= 1'b0;
            r_dst_r     <= 1'b0;
            r_add_done  <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_n   <= i_candidate[NUM_WIDTH-1:0];
                        r_idx <= '0;
                        if (i_candidate[NUM_WIDTH-1:1] == '0) begin
                            r_pass  <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_b     <= fpt64_base(r_idx);
                    r_e     <= r_n - t_num'(1);
                    r_r     <= t_num'(1);
                    r_state <= S_REDUCE;
                end
                S_REDUCE: begin
                    if (w_ge) begin
                        r_b <= w_res;
                    end else begin
                        r_state <= S_POW;
                    end
                end
                S_POW: begin
                    r_acc      <= '0;
                    r_add_done <= 1'b0;
                    if (r_e == '0) begin
                        r_state <= S_CHECK;
                    end else if (r_e[0]) begin
                        r_x     <= r_r;
                        r_y     <= r_b;
                        r_dst_r <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_x     <= r_b;
                        r_y     <= r_b;
                        r_dst_r <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_y == '0) begin
                        r_add_done <= 1'b0;
                        if (r_dst_r) begin
                            r_r     <= r_acc;
                            r_acc   <= '0;
                            r_x     <= r_b;
                            r_y     <= r_b;
                            r_dst_r <= 1'b0;
                        end else begin
                            r_b     <= r_acc;
                            r_e     <= r_e >> 1;
                            r_state <= S_POW;
                        end
                    end else if (w_do_add) begin
                        r_acc      <= w_res;
                        r_add_done <= 1'b1;
                    end else begin
                        r_x        <= w_res;
                        r_y        <= r_y >> 1;
                        r_add_done <= 1'b0;
                    end
                end
                S_CHECK: begin
                    if (r_r != t_num'(1)) begin
                        r_pass  <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_idx == t_base_idx'(NUM_BASES - 1)) begin
                        r_pass  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + t_base_idx'(1);
                        r_state <= S_LOAD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_result    <= r_pass;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fpt64_checker.sv
// Port-level checker for the Fermat probable-prime tester, with its bind.
// Depends on fpt64_pkg and on the top level fermat_prime_test_64_top.
`default_nettype none

module fpt64_checker
    import fpt64_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_valid,
    input wire logic                  o_ready,
    input wire logic [CAND_WIDTH-1:0] i_candidate,
    input wire logic                  o_valid,
    input wire logic                  i_ready,
    input wire logic                  o_is_probable_prime
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid set after reset");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after a request was taken");

    a_request_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_ready) |=> (i_valid && $stable(i_candidate)))
        else $error("waiting request dropped or changed");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_is_probable_prime)))
        else $error("stalled result dropped or changed");

    a_no_result_at_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !o_valid) |=> !o_valid)
        else $error("result appeared one cycle after a request");

endmodule

bind fermat_prime_test_64_top fpt64_checker u_fpt64_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (i_valid),
    .o_ready             (o_ready),
    .i_candidate         (i_candidate),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_is_probable_prime (o_is_probable_prime)
);

`default_nettype wire

FILE: tb/fermat_prime_test_64_top_tb.sv
// Testbench for fermat_prime_test_64_top: a directed table, then random candidates.
// The expected verdicts come from the table or a predictor in this file. It depends on fpt64_pkg and the top.
// Each of the four random phases applies a different idling pattern to the request and result sides.
`default_nettype none

module fermat_prime_test_64_top_tb;
    import fpt64_pkg::*;

    typedef logic [CAND_WIDTH-1:0] t_cand;

    typedef struct packed {
        t_cand cand;
        logic  known;
        logic  verdict;
    } t_probe;

    localparam int NUM_PROBES   = 20;
    localparam int RANDOM_ITEMS = 100;
    localparam int TEST_BASES [NUM_BASES] = '{2, 3, 7, 11};

    localparam t_probe PROBES [NUM_PROBES] = '{
        '{64'd0,                     1'b1, 1'b0},
        '{64'd1,                     1'b1, 1'b0},
        '{64'd2,                     1'b1, 1'b0},
        '{64'd3,                     1'b1, 1'b0},
        '{64'd7,                     1'b1, 1'b0},
        '{64'd11,                    1'b1, 1'b0},
        '{64'd5,                     1'b0, 1'b0},
        '{64'd4,                     1'b0, 1'b0},
        '{64'd1105,                  1'b0, 1'b0},
        '{64'd162401,                1'b0, 1'b0},
        '{64'd1000003,               1'b0, 1'b0},
        '{64'd1000006,               1'b0, 1'b0},
        '{64'h1FFF_FFFF_FFFF_FFFF,   1'b1, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFC5,   1'b1, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF,   1'b0, 1'b0},
        '{64'h8000_0000_0000_0000,   1'b0, 1'b0},
        '{64'h5555_5555_5555_5555,   1'b0, 1'b0},
        '{64'hAAAA_AAAA_AAAA_AAAB,   1'b0, 1'b0},
        '{64'h8000_0000_0000_0001,   1'b0, 1'b0},
        '{64'd4294967291,            1'b0, 1'b0}
    };

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    t_cand i_candidate = '0;
    logic  i_ready = 1'b0;
    logic  o_ready;
    logic  o_valid;
    logic  o_is_probable_prime;

    bit expected_verdicts[$];
    int send_idle_pct = 0;
    int ready_stall_pct = 0;
    int err_count = 0;
    int verdicts_checked = 0;
    int primes_seen = 0;

    fermat_prime_test_64_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_candidate         (i_candidate),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_is_probable_prime (o_is_probable_prime)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #400_000_000;
        $display("fermat_prime_test_64_top verification failed");
        $finish;
    end

    function automatic t_num add_reduced(input t_num x, input t_num y, input t_num m);
        t_wide s;
        s = t_wide'(x) + t_wide'(y);
        if (s >= t_wide'(m)) begin
            s = s - t_wide'(m);
        end
        return t_num'(s);
    endfunction

    function automatic t_num mul_reduced(input t_num x_in, input t_num y_in, input t_num m);
        t_num acc;
        t_num x;
        t_num y;
        acc = '0;
        x = x_in;
        y = y_in;
        for (int k = 0; k < NUM_WIDTH && y != '0; k++) begin
            if (y[0]) begin
                acc = add_reduced(acc, x, m);
            end
            x = add_reduced(x, x, m);
            y = y >> 1;
        end
        return acc;
    endfunction

    function automatic t_num pow_reduced(input t_num b_in, input t_num e_in, input t_num m);
        t_num r;
        t_num b;
        t_num e;
        r = t_num'(1);
        b = b_in % m;
        e = e_in;
        for (int k = 0; k < NUM_WIDTH && e != '0; k++) begin
            if (e[0]) begin
                r = mul_reduced(r, b, m);
            end
            b = mul_reduced(b, b, m);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic bit fermat_verdict(input t_cand cand);
        t_num n;
        n = t_num'(cand);
        if (n < t_num'(2)) begin
            return 1'b0;
        end
        for (int i = 0; i < NUM_BASES; i++) begin
            if (pow_reduced(t_num'(TEST_BASES[i]), n - t_num'(1), n) != t_num'(1)) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_cand rand_of_length(input int len);
        t_cand v;
        v = {$urandom, $urandom};
        if (len < CAND_WIDTH) begin
            v = v & ((t_cand'(1) << len) - t_cand'(1));
        end
        v[len-1] = 1'b1;
        return v;
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return $urandom_range(32, 21);
        end else if (r < 90) begin
            return $urandom_range(48, 33);
        end
        return $urandom_range(64, 49);
    endfunction

    // Walks down over odd values until the four bases all give one, trying at most 4000 values.
    function automatic t_cand nearest_probable_prime(input t_cand start);
        t_cand c;
        c = start | t_cand'(1);
        for (int t = 0; t < 4000; t++) begin
            if (fermat_verdict(c)) begin
                return c;
            end
            c = c - t_cand'(2);
        end
        return c;
    endfunction

    task automatic push_candidate(input t_cand cand, input bit verdict);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_candidate <= cand;
        do @(posedge i_clk); while (!o_ready);
        expected_verdicts.push_back(verdict);
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0b",
                         $time, o_is_probable_prime);
                err_count++;
            end else begin
                bit want;
                want = expected_verdicts.pop_front();
                verdicts_checked++;
                if (o_is_probable_prime) begin
                    primes_seen++;
                end
                if (o_is_probable_prime !== want) begin
                    $display("%0t: is_probable_prime mismatch, expected %0b, actual %0b",
                             $time, want, o_is_probable_prime);
                    err_count++;
                end
            end
        end
    end

    initial begin
        t_cand cand;
        bit    verdict;
        int    r;
        int    len;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PROBES; p++) begin
            cand = PROBES[p].cand;
            verdict = PROBES[p].known ? PROBES[p].verdict : fermat_verdict(cand);
            push_candidate(cand, verdict);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
                1: begin send_idle_pct = 79; ready_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  ready_stall_pct = 79; end
                default: begin send_idle_pct = 25; ready_stall_pct = 25; end
            endcase
            for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
                r = $urandom_range(99);
                len = pick_length();
                if (r < 45) begin
                    cand = nearest_probable_prime(rand_of_length(len));
                end else if (r < 80) begin
                    cand = rand_of_length(len);
                end else begin
                    cand = {$urandom, $urandom};
                end
                push_candidate(cand, fermat_verdict(cand));
            end
        end
        i_valid <= 1'b0;

        while (expected_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);

        $display("Checked %0d verdicts (%0d probable primes) over %0d table rows and %0d random",
                 verdicts_checked, primes_seen, NUM_PROBES, RANDOM_ITEMS);
        $display("candidates, under four idling patterns on the request and result sides.");
        if (err_count == 0) begin
            $display("fermat_prime_test_64_top verification clean");
        end else begin
            $display("fermat_prime_test_64_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
